### rtl/core/bta_pkg.sv
package bta_pkg;

  localparam int TimeBits  = 32;
  localparam int FracBits  = 16;
  localparam int IvBits    = 12 + FracBits;
  localparam int ScoreBits = 48;

  // shared divider: dividend wide enough for gap << frac plus rounding, and for score deltas
  localparam int DivDw = (TimeBits + FracBits + 1 > ScoreBits + 1) ?
                         (TimeBits + FracBits + 1) : (ScoreBits + 1);
  localparam int DivVw = IvBits;

  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 16;

  localparam logic [CfgIdxBits-1:0] CfgInitialInterval  = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgPreMargin        = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgPostMargin       = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgInnerMargin      = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgCorrectionDivisor = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgExpiryTicks      = 3'd5;
  localparam logic [CfgIdxBits-1:0] CfgDecayLimit       = 3'd6;

  localparam logic [11:0] RstInitialInterval   = 12'd512;
  localparam logic [11:0] RstPreMargin         = 12'd102;
  localparam logic [11:0] RstPostMargin        = 12'd205;
  localparam logic [11:0] RstInnerMargin       = 12'd41;
  localparam logic [7:0]  RstCorrectionDivisor = 8'd50;
  localparam logic [15:0] RstExpiryTicks       = 16'd5120;
  localparam logic [15:0] RstDecayLimit        = 16'd0;

  typedef struct packed {
    logic             start;
    logic [DivDw-1:0] dividend;
    logic [DivVw-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DivDw-1:0] quot;
    logic [DivVw-1:0] rem;
  } div_rsp_t;

endpackage

### rtl/core/bta_in_if.sv
interface bta_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] onset_time;
  logic [15:0] salience;

  modport source (output valid, onset_time, salience, input ready);
  modport sink (input valid, onset_time, salience, output ready);
endinterface

### rtl/core/bta_out_if.sv
interface bta_out_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic               expired;
  logic               clone_request;
  logic signed [23:0] beat_error;
  logic [27:0]        current_interval;
  logic [15:0]        beats_counted;
  logic signed [47:0] score;

  modport source (output valid, accepted, expired, clone_request, beat_error,
                  current_interval, beats_counted, score, input ready);
  modport sink (input valid, accepted, expired, clone_request, beat_error,
                current_interval, beats_counted, score, output ready);
endinterface

### rtl/core/bta_div.sv
module bta_div import bta_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CntBits = $clog2(DivDw + 1);

  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivDw-1:0]   quo_q, quo_d;
  logic [DivVw-1:0]   rem_q, rem_d;
  logic [DivVw-1:0]   dvs_q, dvs_d;
  logic [DivVw:0]     trial;
  logic [DivVw:0]     diff;
  logic               ge;

  // restoring division, one quotient bit per cycle; dividend shifts out as quotient shifts in
  always_comb begin
    trial  = {rem_q, quo_q[DivDw-1]};
    ge     = trial >= {1'b0, dvs_q};
    diff   = trial - {1'b0, dvs_q};
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(DivDw);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[DivDw-2:0], ge};
      rem_d = ge ? diff[DivVw-1:0] : trial[DivVw-1:0];
      cnt_d = cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o = '{busy: busy_q, done: done_q, quot: quo_q, rem: rem_q};

endmodule

### rtl/core/beat_tracking_agent_step_unit.sv
// channel   dir  transfer when        payload
// in_i      in   valid && ready       onset_time[31:0], salience[15:0]
// out_o     out  valid && ready       accepted, expired, clone_request, beat_error,
//                                     current_interval, beats_counted, score
// cfg       in   cfg_we_i             cfg_idx_i, cfg_data_i
//
// one event at a time; a bit-serial divider sets the time.
// dead, early, expired, zero-interval or out-of-window events are rejected; only the window test divides.
// first event: correction plus optional decayed score division.
// accepted beat: two to four divisions (window, correction, confidence unless the error
// or its margin is zero, decayed score when decay is on).
// a finished result sits in the output register; the next event is taken meanwhile.
// reset: asynchronous active low, config and agent state to defaults, agent not started.
module beat_tracking_agent_step_unit import bta_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  bta_in_if.sink                in_i,
  bta_out_if.source             out_o
);

  localparam logic [3:0] SIdle     = 4'd0;
  localparam logic [3:0] SCheck    = 4'd1;
  localparam logic [3:0] SDivIv    = 4'd2;
  localparam logic [3:0] SDivCorr  = 4'd3;
  localparam logic [3:0] SDivConf  = 4'd4;
  localparam logic [3:0] SMul      = 4'd5;
  localparam logic [3:0] SScore    = 4'd6;
  localparam logic [3:0] SDivScore = 4'd7;
  localparam logic [3:0] SOut      = 4'd8;

  localparam int EW = IvBits + 2;
  localparam int TermBits = FracBits + 9;
  localparam int SumBits = ScoreBits + 2;
  localparam logic [IvBits-1:0] IvMax = {IvBits{1'b1}};

  // configuration
  logic [11:0] init_iv_q, pre_q, post_q, inner_q;
  logic [7:0]  cdiv_q;
  logic [15:0] expiry_q, decay_q;

  // agent state
  logic [TimeBits-1:0]        last_beat_q, last_beat_d;
  logic [IvBits-1:0]          interval_q, interval_d;
  logic [15:0]                beat_total_q, beat_total_d;
  logic signed [ScoreBits-1:0] score_q, score_d;
  logic                       started_q, started_d;
  logic                       dead_q, dead_d;

  // per-event work registers
  logic [3:0]                 state_q, state_d;
  logic [TimeBits-1:0]        onset_q, onset_d;
  logic [15:0]                sal_q, sal_d;
  logic signed [IvBits:0]     err_q, err_d;
  logic [IvBits-1:0]          aerr_q, aerr_d;
  logic                       acc_q, acc_d;
  logic                       clone_q, clone_d;
  logic signed [23:0]         ticks_q, ticks_d;
  logic [FracBits:0]          conf_q, conf_d;
  logic [TermBits-1:0]        term_q, term_d;
  logic                       dneg_q, dneg_d;

  // output register
  logic                       ovalid_q, ovalid_d;
  logic                       oacc_q, oexp_q, oclone_q;
  logic signed [23:0]         oerr_q;
  logic [27:0]                oiv_q;
  logic [15:0]                obeats_q;
  logic signed [ScoreBits-1:0] oscore_q;
  logic                       oload;

  div_req_t div_req;
  div_rsp_t div_rsp;

  bta_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  function automatic logic signed [ScoreBits-1:0] sat_score(input logic signed [SumBits-1:0] v);
    logic signed [SumBits-1:0] hi;
    logic signed [SumBits-1:0] lo;
    hi = SumBits'({1'b0, {(ScoreBits-1){1'b1}}});
    lo = -hi - SumBits'(1);
    if (v > hi) begin
      sat_score = hi[ScoreBits-1:0];
    end else if (v < lo) begin
      sat_score = lo[ScoreBits-1:0];
    end else begin
      sat_score = v[ScoreBits-1:0];
    end
  endfunction

  logic [TimeBits-1:0]        gap;
  logic [DivDw-1:0]           q_rnd;
  logic [IvBits:0]            r2;
  logic                       rnd_up;
  logic signed [IvBits:0]     err_rnd;
  logic signed [EW-1:0]       err_x, pre_x, post_x, half_x, t_x;
  logic [IvBits:0]            aerr_w;
  logic [16:0]                bsum;
  logic [15:0]                bsat;
  logic signed [EW:0]         cand;
  logic signed [EW+1:0]       dev;
  logic [EW+1:0]              adev;
  logic [EW+4:0]              dev5;
  logic [IvBits-1:0]          init_fx;
  logic [11:0]                margin;
  logic [FracBits+16:0]       prod;
  logic [15:0]                m_sel;
  logic signed [ScoreBits:0]  sdiff;
  logic [ScoreBits:0]         asdiff;
  logic signed [SumBits-1:0]  ssum;
  logic [ScoreBits:0]         qs;

  always_comb begin
    gap     = onset_q - last_beat_q;
    r2      = {div_rsp.rem, 1'b0};
    rnd_up  = (r2 > {1'b0, interval_q}) || ((r2 == {1'b0, interval_q}) && div_rsp.quot[0]);
    q_rnd   = div_rsp.quot + DivDw'(rnd_up);
    err_rnd = rnd_up ? ($signed({1'b0, div_rsp.rem}) - $signed({1'b0, interval_q}))
                     : $signed({1'b0, div_rsp.rem});
    err_x   = EW'(err_rnd);
    pre_x   = $signed({2'b00, pre_q, {FracBits{1'b0}}});
    post_x  = $signed({2'b00, post_q, {FracBits{1'b0}}});
    half_x  = $signed(EW'(1) << (FracBits - 1));
    t_x     = err_x + half_x;
    aerr_w  = err_rnd[IvBits] ? (IvBits+1)'(0) - err_rnd : err_rnd;
    bsum    = {1'b0, beat_total_q} + {1'b0, q_rnd[15:0]};
    bsat    = (bsum[16] || (|q_rnd[DivDw-1:16])) ? 16'hFFFF : bsum[15:0];

    init_fx = {init_iv_q, {FracBits{1'b0}}};
    cand    = err_q[IvBits] ?
              $signed({3'b000, interval_q}) - $signed({3'b000, div_rsp.quot[IvBits-1:0]}) :
              $signed({3'b000, interval_q}) + $signed({3'b000, div_rsp.quot[IvBits-1:0]});
    dev     = $signed({4'b0000, init_fx}) - (EW+2)'(cand);
    adev    = dev[EW+1] ? (EW+2)'(0) - dev : dev;
    dev5    = (EW+5)'({adev, 2'b00}) + (EW+5)'(adev);
    margin  = (!err_q[IvBits]) ? post_q : pre_q;

    prod    = (FracBits+17)'(conf_q) * (FracBits+17)'(sal_q);

    m_sel   = (beat_total_q == 16'd0) ? 16'd1 :
              (beat_total_q > decay_q) ? decay_q : beat_total_q;
    sdiff   = (ScoreBits+1)'(signed'({1'b0, term_q})) - (ScoreBits+1)'(score_q);
    asdiff  = sdiff[ScoreBits] ? (ScoreBits+1)'(0) - sdiff : sdiff;
    qs      = div_rsp.quot[ScoreBits:0];
    ssum    = '0;

    div_req      = '0;
    state_d      = state_q;
    onset_d      = onset_q;
    sal_d        = sal_q;
    err_d        = err_q;
    aerr_d       = aerr_q;
    acc_d        = acc_q;
    clone_d      = clone_q;
    ticks_d      = ticks_q;
    conf_d       = conf_q;
    term_d       = term_q;
    dneg_d       = dneg_q;
    last_beat_d  = last_beat_q;
    interval_d   = interval_q;
    beat_total_d = beat_total_q;
    score_d      = score_q;
    started_d    = started_q;
    dead_d       = dead_q;
    oload        = 1'b0;

    unique case (state_q)
      SIdle: begin
        if (in_i.valid) begin
          onset_d = TimeBits'(in_i.onset_time);
          sal_d   = in_i.salience;
          acc_d   = 1'b0;
          clone_d = 1'b0;
          ticks_d = '0;
          state_d = SCheck;
        end
      end
      SCheck: begin
        priority if (dead_q) begin
          state_d = SOut;
        end else if (!started_q) begin
          started_d    = 1'b1;
          acc_d        = 1'b1;
          err_d        = '0;
          aerr_d       = '0;
          last_beat_d  = onset_q;
          beat_total_d = (beat_total_q == 16'hFFFF) ? beat_total_q : beat_total_q + 16'd1;
          div_req.start    = 1'b1;
          div_req.dividend = '0;
          div_req.divisor  = DivVw'(cdiv_q == 8'd0 ? 8'd1 : cdiv_q);
          state_d      = SDivCorr;
        end else if (onset_q < last_beat_q) begin
          state_d = SOut;
        end else if (gap > TimeBits'(expiry_q)) begin
          dead_d  = 1'b1;
          score_d = -(ScoreBits'(1) << FracBits);
          state_d = SOut;
        end else if (interval_q == '0) begin
          state_d = SOut;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DivDw'({gap, {FracBits{1'b0}}});
          div_req.divisor  = interval_q;
          state_d          = SDivIv;
        end
      end
      SDivIv: begin
        if (div_rsp.done) begin
          if ((q_rnd != '0) && (err_x >= -pre_x) && (err_x <= post_x)) begin
            acc_d        = 1'b1;
            err_d        = err_rnd;
            aerr_d       = aerr_w[IvBits-1:0];
            ticks_d      = 24'(t_x >>> FracBits);
            clone_d      = aerr_w[IvBits-1:0] > {inner_q, {FracBits{1'b0}}};
            last_beat_d  = onset_q;
            beat_total_d = bsat;
            div_req.start    = 1'b1;
            div_req.dividend = DivDw'(aerr_w[IvBits-1:0]);
            div_req.divisor  = DivVw'(cdiv_q == 8'd0 ? 8'd1 : cdiv_q);
            state_d      = SDivCorr;
          end else begin
            state_d = SOut;
          end
        end
      end
      SDivCorr: begin
        if (div_rsp.done) begin
          if (dev5 < (EW+5)'(init_fx)) begin
            if (cand < 0) begin
              interval_d = '0;
            end else if (cand > $signed((EW+1)'(IvMax))) begin
              interval_d = IvMax;
            end else begin
              interval_d = cand[IvBits-1:0];
            end
          end
          if ((aerr_q == '0) || (margin == 12'd0)) begin
            conf_d  = (FracBits+1)'(1) << FracBits;
            state_d = SMul;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DivDw'(aerr_q);
            div_req.divisor  = DivVw'({margin, 1'b0});
            state_d          = SDivConf;
          end
        end
      end
      SDivConf: begin
        if (div_rsp.done) begin
          conf_d  = ((FracBits+1)'(1) << FracBits) - div_rsp.quot[FracBits:0];
          state_d = SMul;
        end
      end
      SMul: begin
        term_d  = prod[FracBits+16:8];
        state_d = SScore;
      end
      SScore: begin
        if (decay_q == 16'd0) begin
          ssum    = SumBits'(score_q) + SumBits'(signed'({1'b0, term_q}));
          score_d = sat_score(ssum);
          state_d = SOut;
        end else begin
          dneg_d           = sdiff[ScoreBits];
          div_req.start    = 1'b1;
          div_req.dividend = DivDw'(asdiff);
          div_req.divisor  = DivVw'(m_sel);
          state_d          = SDivScore;
        end
      end
      SDivScore: begin
        if (div_rsp.done) begin
          ssum = dneg_q ? SumBits'(score_q) - $signed(SumBits'(qs))
                        : SumBits'(score_q) + $signed(SumBits'(qs));
          score_d = sat_score(ssum);
          state_d = SOut;
        end
      end
      SOut: begin
        if (!ovalid_q || out_o.ready) begin
          oload   = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase

    ovalid_d = oload ? 1'b1 : (ovalid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_iv_q <= RstInitialInterval;
      pre_q     <= RstPreMargin;
      post_q    <= RstPostMargin;
      inner_q   <= RstInnerMargin;
      cdiv_q    <= RstCorrectionDivisor;
      expiry_q  <= RstExpiryTicks;
      decay_q   <= RstDecayLimit;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgInitialInterval:   init_iv_q <= cfg_data_i[11:0];
        CfgPreMargin:         pre_q     <= cfg_data_i[11:0];
        CfgPostMargin:        post_q    <= cfg_data_i[11:0];
        CfgInnerMargin:       inner_q   <= cfg_data_i[11:0];
        CfgCorrectionDivisor: cdiv_q    <= cfg_data_i[7:0];
        CfgExpiryTicks:       expiry_q  <= cfg_data_i;
        CfgDecayLimit:        decay_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      last_beat_q  <= '0;
      interval_q   <= {RstInitialInterval, {FracBits{1'b0}}};
      beat_total_q <= '0;
      score_q      <= '0;
      started_q    <= 1'b0;
      dead_q       <= 1'b0;
      ovalid_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      last_beat_q  <= last_beat_d;
      interval_q   <= interval_d;
      beat_total_q <= beat_total_d;
      score_q      <= score_d;
      started_q    <= started_d;
      dead_q       <= dead_d;
      ovalid_q     <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    onset_q <= onset_d;
    sal_q   <= sal_d;
    err_q   <= err_d;
    aerr_q  <= aerr_d;
    acc_q   <= acc_d;
    clone_q <= clone_d;
    ticks_q <= ticks_d;
    conf_q  <= conf_d;
    term_q  <= term_d;
    dneg_q  <= dneg_d;
    if (oload) begin
      oacc_q   <= acc_q;
      oexp_q   <= dead_q;
      oclone_q <= clone_q;
      oerr_q   <= ticks_q;
      oiv_q    <= 28'(interval_q);
      obeats_q <= beat_total_q;
      oscore_q <= score_q;
    end
  end

  assign in_i.ready             = (state_q == SIdle);
  assign out_o.valid            = ovalid_q;
  assign out_o.accepted         = oacc_q;
  assign out_o.expired          = oexp_q;
  assign out_o.clone_request    = oclone_q;
  assign out_o.beat_error       = oerr_q;
  assign out_o.current_interval = oiv_q;
  assign out_o.beats_counted    = obeats_q;
  assign out_o.score            = oscore_q;

  a_clone_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.clone_request |-> out_o.accepted)
    else $error("clone request on a rejected event");

  a_dead_not_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.accepted && out_o.expired))
    else $error("expired agent accepted a beat");

  a_dead_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dead_q |=> dead_q)
    else $error("dead agent came back");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

endmodule
